// ===== hw/rtl/mandelbrot_escape_test_assert.svh =====
// Assertion macros used by the escape test controller
`ifndef MANDELBROT_ESCAPE_TEST_ASSERT_SVH
`define MANDELBROT_ESCAPE_TEST_ASSERT_SVH

// Check that cons holds in the cycle where ante holds
`define MBE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("escape test assertion failed");

// Check that cons holds in the cycle after ante holds
`define MBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("escape test assertion failed");

`endif

// ===== hw/rtl/mbe_pkg.sv =====
// Shared types and constants for the escape test block
package mbe_pkg;

    localparam int FRAC_BITS_DEF = 28;
    localparam int IN_WIDTH      = 30;
    localparam int LIMIT_W       = 10;
    localparam int GRAY_W        = 8;
    localparam int MUL_DIGIT     = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 10'd100;
    localparam logic [GRAY_W-1:0]  GRAY_ESCAPED = 8'd0;
    localparam logic [GRAY_W-1:0]  GRAY_INSIDE  = 8'd255;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK
    } t_state;

    typedef struct packed {
        logic load;
        logic mul_start;
        logic update;
    } t_dp_cmd;

    typedef struct packed {
        logic mul_last;
        logic sq_escape;
        logic bound_escape;
    } t_dp_status;

endpackage

// ===== hw/rtl/mbe_mul.sv =====
// Digit-serial unsigned multiplier, most significant digit of b first
module mbe_mul
    import mbe_pkg::*;
#(
    parameter int MW  = 30,
    parameter int DIG = MUL_DIGIT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [MW-1:0]   i_a,
    input  logic [MW-1:0]   i_b,
    output logic            o_last,
    output logic [2*MW-1:0] o_prod
);

    localparam int NDIG = (MW + DIG - 1) / DIG;
    localparam int BW   = NDIG * DIG;
    localparam int PW   = 2 * MW;
    localparam int SW   = BW + MW;
    localparam int CW   = $clog2(NDIG + 1);

    logic [MW-1:0]     r_a;
    logic [BW-1:0]     r_b;
    logic [PW-1:0]     r_acc;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic [MW+DIG-1:0] w_pp;
    logic [SW-1:0]     w_sum;

    assign w_pp   = r_a * r_b[BW-1 -: DIG];
    assign w_sum  = (SW'(r_acc) << DIG) + SW'(w_pp);
    assign o_last = r_busy && (r_cnt == CW'(NDIG - 1));
    assign o_prod = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (o_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= BW'(i_b);
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= w_sum[PW-1:0];
            r_b   <= r_b << DIG;
        end
    end

endmodule

// ===== hw/rtl/mbe_datapath.sv =====
// Datapath: point and iterate registers, three multipliers, update and escape tests
module mbe_datapath
    import mbe_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    input  logic signed [IN_WIDTH-1:0] i_point_real,
    input  logic signed [IN_WIDTH-1:0] i_point_imag,
    output t_dp_status                 o_status
);

    localparam int MW = (FRAC_BITS + 1 > IN_WIDTH) ? FRAC_BITS + 1 : IN_WIDTH;
    localparam int ZW = MW + 1;
    localparam int PW = 2 * MW;
    localparam int NW = PW + 2;

    localparam logic signed [NW-1:0] BoundPos = NW'(1) << (FRAC_BITS + 1);
    localparam logic signed [NW-1:0] BoundNeg = -BoundPos;
    localparam logic [PW:0]          Four     = (PW + 1)'(1) << (2 * FRAC_BITS + 2);

    logic signed [IN_WIDTH-1:0] r_cr;
    logic signed [IN_WIDTH-1:0] r_ci;
    logic signed [ZW-1:0]       r_zr;
    logic signed [ZW-1:0]       r_zi;
    logic signed [ZW-1:0]       n_zr;
    logic signed [ZW-1:0]       n_zi;

    logic [MW-1:0]        w_ar;
    logic [MW-1:0]        w_ai;
    logic [PW-1:0]        w_sr;
    logic [PW-1:0]        w_si;
    logic [PW-1:0]        w_pr;
    logic                 w_last_sr;
    logic                 w_last_si;
    logic                 w_last_pr;
    logic signed [NW-1:0] w_diff;
    logic signed [NW-1:0] w_dsh;
    logic [PW:0]          w_p2;
    logic signed [NW-1:0] w_prod2;
    logic signed [NW-1:0] w_psh;
    logic signed [NW-1:0] w_cr_ext;
    logic signed [NW-1:0] w_ci_ext;
    logic signed [NW-1:0] w_nr;
    logic signed [NW-1:0] w_ni;
    logic [PW:0]          w_sq;
    logic                 w_neg;

    assign w_cr_ext = {{(NW - IN_WIDTH){r_cr[IN_WIDTH-1]}}, r_cr};
    assign w_ci_ext = {{(NW - IN_WIDTH){r_ci[IN_WIDTH-1]}}, r_ci};

    assign w_diff  = $signed({2'b00, w_sr}) - $signed({2'b00, w_si});
    assign w_dsh   = w_diff >>> FRAC_BITS;
    assign w_nr    = w_dsh + w_cr_ext;

    assign w_neg   = r_zr[ZW-1] ^ r_zi[ZW-1];
    assign w_p2    = {w_pr, 1'b0};
    assign w_prod2 = w_neg ? -$signed({1'b0, w_p2}) : $signed({1'b0, w_p2});
    assign w_psh   = w_prod2 >>> FRAC_BITS;
    assign w_ni    = w_psh + w_ci_ext;

    assign w_sq    = {1'b0, w_sr} + {1'b0, w_si};

    always_comb begin
        priority if (i_cmd.load) begin
            n_zr = {{(ZW - IN_WIDTH){i_point_real[IN_WIDTH-1]}}, i_point_real};
            n_zi = {{(ZW - IN_WIDTH){i_point_imag[IN_WIDTH-1]}}, i_point_imag};
        end else if (i_cmd.update) begin
            n_zr = w_nr[ZW-1:0];
            n_zi = w_ni[ZW-1:0];
        end else begin
            n_zr = r_zr;
            n_zi = r_zi;
        end
    end

    assign w_ar = n_zr[ZW-1] ? MW'(-n_zr) : MW'(n_zr);
    assign w_ai = n_zi[ZW-1] ? MW'(-n_zi) : MW'(n_zi);

    always_ff @(posedge i_clk) begin
        r_zr <= n_zr;
        r_zi <= n_zi;
        if (i_cmd.load) begin
            r_cr <= i_point_real;
            r_ci <= i_point_imag;
        end
    end

    mbe_mul #(.MW(MW), .DIG(MUL_DIGIT)) u_mul_sr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (w_ar),
        .i_b     (w_ar),
        .o_last  (w_last_sr),
        .o_prod  (w_sr)
    );

    mbe_mul #(.MW(MW), .DIG(MUL_DIGIT)) u_mul_si (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (w_ai),
        .i_b     (w_ai),
        .o_last  (w_last_si),
        .o_prod  (w_si)
    );

    mbe_mul #(.MW(MW), .DIG(MUL_DIGIT)) u_mul_pr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (w_ar),
        .i_b     (w_ai),
        .o_last  (w_last_pr),
        .o_prod  (w_pr)
    );

    assign o_status.mul_last     = w_last_sr & w_last_si & w_last_pr;
    assign o_status.sq_escape    = (w_sq >= Four);
    assign o_status.bound_escape = (w_nr >= BoundPos) || (w_nr <= BoundNeg) ||
                                   (w_ni >= BoundPos) || (w_ni <= BoundNeg);

endmodule

// ===== hw/rtl/mbe_ctrl.sv =====
// Controller: iteration sequencing, limit register and result strobe
`include "mandelbrot_escape_test_assert.svh"

module mbe_ctrl
    import mbe_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_data,
    input  t_dp_status         i_status,
    output t_dp_cmd            o_cmd,
    output logic               o_result_valid,
    output logic               o_escaped,
    output logic [GRAY_W-1:0]  o_gray_level
);

    t_state             r_state;
    t_state             n_state;
    logic [LIMIT_W-1:0] r_limit;
    logic [LIMIT_W-1:0] r_iter;
    logic [LIMIT_W-1:0] n_iter;
    logic               r_done;
    logic               n_done;
    logic               r_escaped;
    logic               n_escaped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_limit <= LIMIT_RESET;
            r_iter  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_escaped <= n_escaped;
    end

    always_comb begin
        n_state   = r_state;
        n_iter    = r_iter;
        n_done    = 1'b0;
        n_escaped = r_escaped;
        o_cmd     = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load      = 1'b1;
                    o_cmd.mul_start = 1'b1;
                    n_iter          = '0;
                    n_state         = ST_MUL;
                end
            end
            ST_MUL: begin
                if (i_status.mul_last) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                priority if ((r_iter != '0) && i_status.sq_escape) begin
                    n_done    = 1'b1;
                    n_escaped = 1'b1;
                    n_state   = ST_IDLE;
                end else if (r_iter == r_limit) begin
                    n_done    = 1'b1;
                    n_escaped = 1'b0;
                    n_state   = ST_IDLE;
                end else if (i_status.bound_escape) begin
                    n_done    = 1'b1;
                    n_escaped = 1'b1;
                    n_state   = ST_IDLE;
                end else begin
                    o_cmd.update    = 1'b1;
                    o_cmd.mul_start = 1'b1;
                    n_iter          = r_iter + 1'b1;
                    n_state         = ST_MUL;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy         = (r_state != ST_IDLE);
    assign o_result_valid = r_done;
    assign o_escaped      = r_escaped;
    assign o_gray_level   = r_escaped ? GRAY_ESCAPED : GRAY_INSIDE;

    `MBE_ASSERT_NEXT(a_accept_to_mul, i_clk, i_rst_n, i_start && (r_state == ST_IDLE), r_state == ST_MUL)
    `MBE_ASSERT_NOW(a_done_in_idle, i_clk, i_rst_n, r_done, r_state == ST_IDLE)
    `MBE_ASSERT_NOW(a_done_after_check, i_clk, i_rst_n, r_done, $past(r_state) == ST_CHECK)

endmodule

// ===== hw/rtl/mandelbrot_escape_test.sv =====
// Top level of the Mandelbrot escape time test
//
// Channel    Direction  Signals                          Transaction
// point      in         start, busy, i_point_real/imag   start high, busy low at edge
// result     out        o_result_valid, o_escaped,       one cycle strobe, always taken
//                       o_gray_level
// config     in         i_cfg_we, i_cfg_data             write at edge with i_cfg_we high
//
// One pass is NDIG digit steps of the three shared multipliers, NDIG = ceil(max(FRAC_BITS+1,30)/32),
// plus one update and test step.
// A point takes k passes, k at most iteration_limit+1; the result strobe follows in the
// next cycle, when busy is already low and a new point may start.
// Reset is synchronous and active low; the iteration limit returns to 100.
// The result side cannot stall; busy holds off new points while one is in work.
module mandelbrot_escape_test
    import mbe_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_cfg_we,
    input  logic [LIMIT_W-1:0]         i_cfg_data,
    input  logic signed [IN_WIDTH-1:0] i_point_real,
    input  logic signed [IN_WIDTH-1:0] i_point_imag,
    output logic                       o_result_valid,
    output logic                       o_escaped,
    output logic [GRAY_W-1:0]          o_gray_level
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    mbe_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_status       (w_status),
        .o_cmd          (w_cmd),
        .o_result_valid (o_result_valid),
        .o_escaped      (o_escaped),
        .o_gray_level   (o_gray_level)
    );

    mbe_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_point_real (i_point_real),
        .i_point_imag (i_point_imag),
        .o_status     (w_status)
    );

endmodule
